/* rtl/sliding_window_min_variance_delta_macros.svh */
// Assertion macros for the sliding window minimum and variance block.
`ifndef SLIDING_WINDOW_MIN_VARIANCE_DELTA_MACROS_SVH
`define SLIDING_WINDOW_MIN_VARIANCE_DELTA_MACROS_SVH

// General form: clocked, disabled while reset is low.
`define SWMVD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Next-cycle implication on the checker's clk_i and rst_ni.
`define SWMVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SWMVD_ASSERT(lbl, clk_i, rst_ni, (ante) |=> (cons), msg)

`endif

/* rtl/swmvd_pkg.sv */
// Shared constants and control types for the sliding window minimum and variance block.
package swmvd_pkg;

  localparam int WINDOW_DEPTH_DEF = 50;
  localparam int RATIO_WIDTH_DEF  = 24;
  localparam int VAR_W            = 48;
  localparam int ACC_W            = 64;
  localparam int DIV_W            = 64;
  localparam int DIV_STEP_W       = $clog2(DIV_W + 1);

  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  typedef struct packed {
    logic take;
    logic acc_clr;
    logic rd_en;
    logic pass_dev;
    logic div_start;
    logic div_var;
    logic res_load;
  } swmvd_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_busy;
  } swmvd_sts_t;

endpackage

/* rtl/swmvd_div.sv */
// Restoring serial divider, one quotient bit per cycle, dividend left-aligned.
module swmvd_div
  import swmvd_pkg::*;
#(
  parameter int DIVISOR_W = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIV_W-1:0]      dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  input  logic [DIV_STEP_W-1:0] steps_i,
  output logic                  busy_o,
  output logic [DIV_W-1:0]      quotient_o
);

  logic [DIV_STEP_W-1:0] cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIV_W-1:0]      quo_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= steps_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

/* rtl/swmvd_dp.sv */
// Datapath: window memory, delta, minimum and sum pass, deviation squares, result registers.
module swmvd_dp
  import swmvd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int RATIO_WIDTH  = RATIO_WIDTH_DEF,
  parameter int IDX_W        = $clog2(WINDOW_DEPTH),
  parameter int CNT_W        = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  swmvd_cmd_t              cmd_i,
  input  logic [RATIO_WIDTH-1:0]  ratio_i,
  input  logic [IDX_W-1:0]        rd_addr_i,
  output swmvd_sts_t              sts_o,
  output logic [CNT_W-1:0]        count_o,
  output logic [RATIO_WIDTH:0]    delta_o,
  output logic [RATIO_WIDTH-1:0]  baseline_o,
  output logic [VAR_W-1:0]        variance_o,
  output logic                    full_o
);

  localparam int W     = RATIO_WIDTH;
  localparam int SUM_W = W + CNT_W;

  logic signed [W-1:0]     mem_q [WINDOW_DEPTH];
  logic signed [W-1:0]     rd_data_q;
  logic [IDX_W-1:0]        wr_idx_q;
  logic [IDX_W-1:0]        wr_idx_d;
  logic                    full_q;
  logic signed [W-1:0]     prev_q;
  logic signed [W:0]       delta_q;
  logic                    v1_q, v2_q, v3_q;
  logic                    first_q;
  logic signed [W-1:0]     min_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    sum_neg_q;
  logic signed [W:0]       mean_q;
  logic [W-1:0]            abs_q;
  logic [2*W-1:0]          sq_q;
  logic [ACC_W-1:0]        acc_q;
  logic [ACC_W:0]          acc_sum;
  logic                    div_run_q;
  logic                    div_var_q;
  logic [VAR_W-1:0]        var_q;

  logic [SUM_W-1:0]        sum_mag;
  logic [DIV_W-1:0]        div_dividend;
  logic [DIV_STEP_W-1:0]   div_steps;
  logic                    div_busy;
  logic [DIV_W-1:0]        div_quo;
  logic [W-1:0]            mean_mag;
  logic signed [W+1:0]     dev;
  logic [W+1:0]            dev_abs;

  logic [W:0]              out_delta_q;
  logic [W-1:0]            out_base_q;
  logic [VAR_W-1:0]        out_var_q;
  logic                    out_full_q;

  assign wr_idx_d = (wr_idx_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
  assign count_o  = full_q ? CNT_W'(WINDOW_DEPTH) : CNT_W'(wr_idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mem_q[wr_idx_q] <= $signed(ratio_i);
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      full_q   <= 1'b0;
      prev_q   <= '0;
    end else if (cmd_i.take) begin
      wr_idx_q <= wr_idx_d;
      prev_q   <= $signed(ratio_i);
      if (wr_idx_d == '0) begin
        full_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      delta_q <= (W+1)'($signed(ratio_i)) - (W+1)'(prev_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q & cmd_i.pass_dev;
      v3_q <= v2_q;
    end
  end

  assign sts_o.pipe_busy = v1_q | v2_q | v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
    end else if (cmd_i.acc_clr) begin
      first_q <= 1'b1;
    end else if (v1_q && !cmd_i.pass_dev) begin
      first_q <= 1'b0;
    end
  end

  assign dev     = (W+2)'(rd_data_q) - (W+2)'(mean_q);
  assign dev_abs = dev[W+1] ? (W+2)'(-dev) : (W+2)'(dev);
  assign acc_sum = {1'b0, acc_q} + (ACC_W+1)'(sq_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      sum_q <= '0;
      acc_q <= '0;
    end else begin
      if (v1_q && !cmd_i.pass_dev) begin
        if (first_q || rd_data_q < min_q) begin
          min_q <= rd_data_q;
        end
        sum_q <= sum_q + SUM_W'(rd_data_q);
      end
      if (v3_q) begin
        acc_q <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
      end
    end
    if (v1_q && cmd_i.pass_dev) begin
      abs_q <= dev_abs[W-1:0];
    end
    if (v2_q) begin
      sq_q <= abs_q * abs_q;
    end
  end

  assign sum_mag      = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign div_dividend = cmd_i.div_var ? DIV_W'(acc_q)
                                      : (DIV_W'(sum_mag) << (DIV_W - SUM_W));
  assign div_steps    = cmd_i.div_var ? DIV_STEP_W'(DIV_W) : DIV_STEP_W'(SUM_W);

  swmvd_div #(
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (count_o),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign mean_mag = div_quo[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_run_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      div_run_q <= 1'b1;
    end else if (!div_busy) begin
      div_run_q <= 1'b0;
    end
  end

  assign sts_o.div_busy = div_run_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_var_q <= cmd_i.div_var;
      sum_neg_q <= sum_q[SUM_W-1];
    end
    if (div_run_q && !div_busy) begin
      if (div_var_q) begin
        var_q <= (|div_quo[DIV_W-1:VAR_W]) ? VAR_MAX : div_quo[VAR_W-1:0];
      end else begin
        mean_q <= sum_neg_q ? -$signed({1'b0, mean_mag}) : $signed({1'b0, mean_mag});
      end
    end
    if (cmd_i.res_load) begin
      out_delta_q <= delta_q;
      out_base_q  <= min_q;
      out_var_q   <= var_q;
      out_full_q  <= full_q;
    end
  end

  assign delta_o    = out_delta_q;
  assign baseline_o = out_base_q;
  assign variance_o = out_var_q;
  assign full_o     = out_full_q;

endmodule

/* rtl/swmvd_ctrl.sv */
// Controller: sequences the write, the two window passes, the two divisions and the result beat.
module swmvd_ctrl
  import swmvd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int IDX_W        = $clog2(WINDOW_DEPTH),
  parameter int CNT_W        = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  swmvd_sts_t       sts_i,
  input  logic [CNT_W-1:0] count_i,
  output swmvd_cmd_t       cmd_o,
  output logic [IDX_W-1:0] rd_addr_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_MEAN_DIV,
    ST_MEAN_WAIT,
    ST_DEV,
    ST_DEV_DRAIN,
    ST_VAR_DIV,
    ST_VAR_WAIT,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic             last;

  assign last = (idx_q == count_i - CNT_W'(1));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take    = 1'b1;
          cmd_o.acc_clr = 1'b1;
          idx_d         = '0;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        idx_d       = idx_q + 1'b1;
        if (last) begin
          idx_d   = '0;
          state_d = ST_SCAN_DRAIN;
        end
      end
      ST_SCAN_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_MEAN_DIV;
        end
      end
      ST_MEAN_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_DEV;
        end
      end
      ST_DEV: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.pass_dev = 1'b1;
        idx_d          = idx_q + 1'b1;
        if (last) begin
          idx_d   = '0;
          state_d = ST_DEV_DRAIN;
        end
      end
      ST_DEV_DRAIN: begin
        cmd_o.pass_dev = 1'b1;
        if (!sts_i.pipe_busy) begin
          state_d = ST_VAR_DIV;
        end
      end
      ST_VAR_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_var   = 1'b1;
        state_d         = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign rd_addr_o   = idx_q[IDX_W-1:0];

endmodule

/* rtl/sliding_window_min_variance_delta.sv */
// Top level of the sliding window minimum, variance and delta block.
// Input channel s_axis: one beat carries one ratio sample (signed Q8.16).
// Output channel m_axis: one beat per sample with the delta to the previous
// sample, the minimum over the valid window entries, the population variance
// (unsigned Q16.32, saturating) in tdata, and the window-full flag in tuser.
// Each sample is written into a circular window of WINDOW_DEPTH entries; the
// valid entries are then read twice through the single memory read port, once
// for minimum and sum, once for the squared deviations, with a serial divider
// (one quotient bit per cycle) for the mean and for the variance.
// One sample is processed at a time: s_axis_tready is high only while the
// block is idle, from the cycle after each result is loaded, so a new sample
// is not taken before the block is through with the last one.
// The result sits in an output register, so the next sample is taken while the
// previous beat still waits; if the receiver stalls longer, the finished result
// holds until the output register frees.
// Reset clears the write index, the full flag and the previous sample; no
// clearing pass is needed since only written entries are ever read.
module sliding_window_min_variance_delta
  import swmvd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int RATIO_WIDTH  = RATIO_WIDTH_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              s_axis_tvalid,
  output logic                                              s_axis_tready,
  // ratio_in
  input  logic [((RATIO_WIDTH + 7) / 8) * 8 - 1:0]          s_axis_tdata,
  output logic                                              m_axis_tvalid,
  input  logic                                              m_axis_tready,
  // delta_out, baseline_out, variance_out
  output logic [((2 * RATIO_WIDTH + VAR_W + 8) / 8) * 8 - 1:0] m_axis_tdata,
  // window_full_out
  output logic                                              m_axis_tuser
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int OUT_W = ((2 * RATIO_WIDTH + VAR_W + 8) / 8) * 8;

  swmvd_cmd_t             cmd;
  swmvd_sts_t             sts;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       rd_addr;
  logic [RATIO_WIDTH:0]   delta;
  logic [RATIO_WIDTH-1:0] baseline;
  logic [VAR_W-1:0]       variance;

  swmvd_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .count_i     (count),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  swmvd_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .RATIO_WIDTH  (RATIO_WIDTH),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .ratio_i    (s_axis_tdata[RATIO_WIDTH-1:0]),
    .rd_addr_i  (rd_addr),
    .sts_o      (sts),
    .count_o    (count),
    .delta_o    (delta),
    .baseline_o (baseline),
    .variance_o (variance),
    .full_o     (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_W'({variance, baseline, delta});

endmodule

/* rtl/swmvd_checker.sv */
// Port-level checker for the sliding window block and its bind.
`include "sliding_window_min_variance_delta_macros.svh"

module swmvd_checker
  import swmvd_pkg::*;
#(
  parameter int RATIO_WIDTH = RATIO_WIDTH_DEF
) (
  input logic                                                 clk_i,
  input logic                                                 rst_ni,
  input logic                                                 s_axis_tvalid,
  input logic                                                 s_axis_tready,
  input logic                                                 m_axis_tvalid,
  input logic                                                 m_axis_tready,
  input logic [((2 * RATIO_WIDTH + VAR_W + 8) / 8) * 8 - 1:0] m_axis_tdata,
  input logic                                                 m_axis_tuser
);

  `SWMVD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")
  `SWMVD_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")
  `SWMVD_ASSERT_NEXT(a_one_sample, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second sample taken while one is in work")
  `SWMVD_ASSERT_NEXT(a_full_sticky, m_axis_tvalid && m_axis_tuser, !m_axis_tvalid || m_axis_tuser, "window full flag cleared")

endmodule

bind sliding_window_min_variance_delta swmvd_checker #(
  .RATIO_WIDTH (RATIO_WIDTH)
) u_swmvd_checker (.*);

/* bench/sliding_window_min_variance_delta_tb.sv */
// Testbench for the sliding window minimum, variance and delta block.
module sliding_window_min_variance_delta_tb;
  import swmvd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH  = WINDOW_DEPTH_DEF;
  localparam int RW     = RATIO_WIDTH_DEF;
  localparam int IN_W   = ((RW + 7) / 8) * 8;
  localparam int OUT_W  = ((2 * RW + VAR_W + 8) / 8) * 8;
  localparam int RANDOM_SAMPLES = 500;
  localparam int DRAIN_CYCLES   = 300;
  localparam logic signed [RW-1:0] RATIO_MAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic signed [RW-1:0] RATIO_MIN = {1'b1, {(RW-1){1'b0}}};

  typedef struct packed {
    logic signed [RW:0]   delta;
    logic signed [RW-1:0] baseline;
    logic [VAR_W-1:0]     variance;
    logic                 full;
  } window_stats_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;

  sliding_window_min_variance_delta DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  longint          win_samples [DEPTH];
  int unsigned     win_wr_idx;
  bit              win_full;
  longint          last_sample;
  window_stats_t   pending_stats[$];
  int unsigned     mismatch_count = 0;
  int unsigned     burst_left;

  function automatic window_stats_t window_stats_after(logic signed [RW-1:0] sample);
    window_stats_t    res;
    longint           xs;
    longint           min_val;
    longint           sum;
    longint           mean;
    longint           dev;
    longint unsigned  mag;
    longint unsigned  sq;
    longint unsigned  sq_sum;
    longint unsigned  var_q;
    int unsigned      count;
    xs = longint'(sample);
    res.delta = (RW+1)'(xs - last_sample);
    win_samples[win_wr_idx] = xs;
    win_wr_idx++;
    if (win_wr_idx >= DEPTH) begin
      win_wr_idx = 0;
      win_full   = 1'b1;
    end
    last_sample = xs;
    count = win_full ? DEPTH : win_wr_idx;
    if (count == 0) count = 1;
    min_val = win_samples[0];
    sum     = 0;
    for (int i = 0; i < count; i++) begin
      if (win_samples[i] < min_val) min_val = win_samples[i];
      sum += win_samples[i];
    end
    mean   = sum / longint'(count);
    sq_sum = 0;
    for (int i = 0; i < count; i++) begin
      dev = win_samples[i] - mean;
      mag = (dev < 0) ? longint'(-dev) : longint'(dev);
      sq  = mag * mag;
      if (sq_sum > ~64'd0 - sq) sq_sum = ~64'd0;
      else sq_sum += sq;
    end
    var_q = sq_sum / longint'(count);
    if (var_q > longint'(VAR_MAX)) var_q = longint'(VAR_MAX);
    res.baseline = RW'(min_val);
    res.variance = var_q[VAR_W-1:0];
    res.full     = win_full;
    return res;
  endfunction

  task automatic send_sample(logic signed [RW-1:0] sample);
    s_axis_tdata  <= IN_W'(sample);
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_stats.push_back(window_stats_after(sample));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3:       begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(40, 260)) @(posedge clk_i);
        end
        default: begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk_i);
        end
      endcase
    end
  endtask

  // receiver: runs of always-ready, random ready and long stalls
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 400);
      m_axis_tready <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (stall_left % 300) < 100;
      endcase
    end
  end

  always @(posedge clk_i) begin
    window_stats_t exp_stats;
    window_stats_t got_stats;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_stats.delta    = m_axis_tdata[RW:0];
      got_stats.baseline = m_axis_tdata[2*RW:RW+1];
      got_stats.variance = m_axis_tdata[2*RW+VAR_W:2*RW+1];
      got_stats.full     = m_axis_tuser;
      if (pending_stats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: delta %0d min %0d var %0d full %0b",
                   got_stats.delta, got_stats.baseline, got_stats.variance,
                   got_stats.full);
      end else begin
        exp_stats = pending_stats.pop_front();
        if (got_stats !== exp_stats) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp delta %0d min %0d var %0d full %0b,",
                     exp_stats.delta, exp_stats.baseline, exp_stats.variance,
                     exp_stats.full,
                     " got delta %0d min %0d var %0d full %0b",
                     got_stats.delta, got_stats.baseline,
                     got_stats.variance, got_stats.full);
        end
      end
    end
  end

  task automatic test_extreme_samples();
    send_sample(RATIO_MAX);
    send_sample(RATIO_MIN);
    send_sample(RATIO_MAX);
    send_sample('0);
    send_sample(RW'(-1));
    send_sample(RW'(1));
    send_sample(RW'(24'h555555));
    send_sample(RW'(24'hAAAAAA));
    for (int i = 0; i < 6; i++) begin
      send_sample(RATIO_MIN);
      send_sample(RATIO_MAX);
    end
    send_sample(RATIO_MAX);
    send_sample(RATIO_MIN);
  endtask

  task automatic test_random_samples();
    logic signed [RW-1:0] level;
    logic signed [RW-1:0] sample;
    level = RW'($urandom);
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      if ($urandom_range(0, 39) == 0) level = RW'($urandom);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
          sample = RW'($urandom);
        10, 11, 12, 13, 14:
          sample = level + RW'($urandom_range(0, 511)) - RW'(256);
        15, 16:
          sample = RW'($urandom_range(0, 31)) - RW'(16);
        17:      sample = RATIO_MAX;
        18:      sample = RATIO_MIN;
        default: sample = level;
      endcase
      send_sample(sample);
    end
  endtask

  initial begin
    win_wr_idx     = 0;
    win_full       = 1'b0;
    last_sample    = 0;
    burst_left     = 1;
    foreach (win_samples[i]) win_samples[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extreme_samples();
    test_random_samples();
    s_axis_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_stats.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
